### hw/rtl/ckr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckr_pkg: shared types and codes of the checkpoint chunk reassembler
// Item modes, result status codes and the classified command that the
// front end hands to the back end through the command queue.
// ----------------------------------------------------------------------------
package ckr_pkg;

   // Wide enough for any buffer size and chunk size the block supports
   // (buffer up to 2^20 bytes, chunk up to 8192 bytes).
   localparam int POS_W = 21;
   localparam int LEN_W = 14;

   localparam logic [2:0] MODE_BEGIN = 3'd0;
   localparam logic [2:0] MODE_CHUNK = 3'd1;
   localparam logic [2:0] MODE_DATA  = 3'd2;
   localparam logic [2:0] MODE_ACK   = 3'd3;
   localparam logic [2:0] MODE_READ  = 3'd4;
   localparam logic [2:0] MODE_CLEAR = 3'd5;

   typedef enum logic [2:0] {
      ST_ACCEPTED  = 3'd0,
      ST_IGNORED   = 3'd1,
      ST_BUSY      = 3'd2,
      ST_TOO_LARGE = 3'd3,
      ST_REJECTED  = 3'd4,
      ST_COMPLETE  = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      CMD_IGNORE,
      CMD_BEGIN,
      CMD_CHUNK,
      CMD_DATA,
      CMD_READ,
      CMD_CLEAR
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type     kind;
      logic             too_big;    // begin: total above buffer size
      logic             too_far;    // chunk: end lies beyond the position range
      logic             short_pay;  // chunk: payload shorter than clamped length
      logic [63:0]      tag;
      logic [63:0]      seq;
      logic [POS_W-1:0] total;
      logic [31:0]      chunks;
      logic [31:0]      cnum;
      logic [LEN_W-1:0] size;
      logic [POS_W-1:0] offset;
      logic [POS_W-1:0] end_pos;
      logic [7:0]       data;
      logic [14:0]      raddr;
   } cmd_type;

endpackage

### hw/rtl/ckr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckr_front: item intake and classification
// Holds the node number register, decodes each accepted item into a command
// and precomputes the chunk bounds that do not depend on transfer state.
// ----------------------------------------------------------------------------
module ckr_front
   import ckr_pkg::*;
#(
   parameter int BUF_BYTES  = 32768,
   parameter int CHUNK_SIZE = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   input  logic        accept,
   input  logic [2:0]  req_mode,
   input  logic [15:0] req_dest_node,
   input  logic [63:0] req_transfer_tag,
   input  logic [63:0] req_seq_number,
   input  logic [31:0] req_total_len,
   input  logic [31:0] req_chunk_count,
   input  logic [31:0] req_chunk_number,
   input  logic [31:0] req_chunk_len,
   input  logic [15:0] req_payload_len,
   input  logic [7:0]  req_data_byte,
   input  logic [14:0] req_read_addr,
   output logic        push,
   output cmd_type     push_cmd
);

   localparam logic [31:0] BUF_LIM   = 32'(BUF_BYTES);
   localparam logic [31:0] CHUNK_LIM = 32'(CHUNK_SIZE);

   logic [15:0]      local_node_ff;
   logic [15:0]      local_node_in;
   logic             dest_hit;
   logic [LEN_W-1:0] size;
   logic [47:0]      offset_w;
   logic [47:0]      end_w;

   assign local_node_in = csr_wr_en ? csr_wr_data : local_node_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         local_node_ff <= '0;
      end else begin
         local_node_ff <= local_node_in;
      end
   end

   assign dest_hit = (req_dest_node == local_node_ff);
   assign size     = (req_chunk_len > CHUNK_LIM) ? LEN_W'(CHUNK_SIZE)
                                                 : req_chunk_len[LEN_W-1:0];
   assign offset_w = 48'(req_chunk_number) * 48'(CHUNK_SIZE);
   assign end_w    = offset_w + 48'(size);

   always_comb begin
      push_cmd           = '0;
      push_cmd.kind      = CMD_IGNORE;
      push_cmd.too_big   = (req_total_len > BUF_LIM);
      push_cmd.too_far   = |end_w[47:POS_W];
      push_cmd.short_pay = (req_payload_len < 16'(size));
      push_cmd.tag       = req_transfer_tag;
      push_cmd.seq       = req_seq_number;
      push_cmd.total     = req_total_len[POS_W-1:0];
      push_cmd.chunks    = req_chunk_count;
      push_cmd.cnum      = req_chunk_number;
      push_cmd.size      = size;
      push_cmd.offset    = offset_w[POS_W-1:0];
      push_cmd.end_pos   = end_w[POS_W-1:0];
      push_cmd.data      = req_data_byte;
      push_cmd.raddr     = req_read_addr;
      case (req_mode)
         MODE_BEGIN: begin
            if (dest_hit) begin
               push_cmd.kind = CMD_BEGIN;
            end
         end
         MODE_CHUNK: begin
            if (dest_hit) begin
               push_cmd.kind = CMD_CHUNK;
            end
         end
         MODE_DATA:  push_cmd.kind = CMD_DATA;
         MODE_ACK:   push_cmd.kind = CMD_IGNORE;
         MODE_READ:  push_cmd.kind = CMD_READ;
         MODE_CLEAR: push_cmd.kind = CMD_CLEAR;
         default:    push_cmd.kind = CMD_IGNORE;
      endcase
   end

   assign push = accept;

endmodule

### hw/rtl/ckr_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckr_queue: command queue between front and back end
// Four-entry first-in first-out store of classified commands.
// ----------------------------------------------------------------------------
module ckr_queue
   import ckr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output logic    full,
   output logic    head_valid,
   output cmd_type head_cmd
);

   localparam int DEPTH = 4;
   localparam int PW    = $clog2(DEPTH);

   cmd_type         entry_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff;
   logic [PW-1:0]   wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff;
   logic [PW-1:0]   rd_ptr_in;
   logic [PW:0]     count_ff;
   logic [PW:0]     count_in;
   logic            do_push;
   logic            do_pop;

   assign full       = (count_ff == (PW + 1)'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### hw/rtl/ckr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckr_back: transfer state, byte store and result register
// Executes one queued command per cycle unless clearing, against the transfer
// state, writes and reads the byte store and registers the result. An accepted
// begin zeroes the announced span of the store before the next command runs.
// ----------------------------------------------------------------------------
module ckr_back
   import ckr_pkg::*;
#(
   parameter int BUF_BYTES = 32768
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        head_valid,
   input  cmd_type     head_cmd,
   output logic        pop,
   output logic        rsp_strobe,
   output logic [2:0]  rsp_status,
   output logic        rsp_active_flag,
   output logic        rsp_complete_flag,
   output logic [15:0] rsp_ready_size,
   output logic [63:0] rsp_done_seq,
   output logic [7:0]  rsp_read_data
);

   localparam int AW  = $clog2(BUF_BYTES);
   localparam int RAW = (AW > 15) ? AW : 15;
   localparam logic [POS_W-1:0] BUF_LIM = POS_W'(BUF_BYTES);

   logic [7:0]       mem [BUF_BYTES];
   logic [7:0]       mem_q_ff;

   logic             recv_ff, recv_in;
   logic             fin_ff, fin_in;
   logic             open_ff, open_in;
   logic [POS_W-1:0] total_ff, total_in;
   logic [31:0]      chunks_ff, chunks_in;
   logic [63:0]      seq_ff, seq_in;
   logic [63:0]      tag_ff, tag_in;
   logic [POS_W-1:0] got_ff, got_in;
   logic [POS_W-1:0] wptr_ff, wptr_in;
   logic [LEN_W-1:0] left_ff, left_in;
   logic [POS_W-1:0] clr_left_ff, clr_left_in;

   logic             rsp_strobe_ff;
   status_type       status_ff, status_in;
   logic             rd_hit_ff, rd_hit_in;
   logic [POS_W-1:0] ready_total_ff;
   logic             ready_fin_ff;
   logic             active_ff;
   logic [63:0]      done_seq_ff;

   logic             clearing;
   logic             mem_we;
   logic [AW-1:0]    mem_waddr;
   logic [7:0]       mem_wdata;
   logic             rd_req;
   logic [AW-1:0]    rd_addr;
   logic [RAW-1:0]   raddr_w;
   logic [POS_W-1:0] got_inc;
   logic [POS_W-1:0] clr_addr;

   assign clearing = (clr_left_ff != '0);
   assign pop      = head_valid && !clearing;
   assign got_inc  = (got_ff == '1) ? got_ff : got_ff + 1'b1;
   assign raddr_w  = RAW'(head_cmd.raddr);
   assign rd_addr  = raddr_w[AW-1:0];
   assign clr_addr = clr_left_ff - 1'b1;

   always_comb begin
      recv_in     = recv_ff;
      fin_in      = fin_ff;
      open_in     = open_ff;
      total_in    = total_ff;
      chunks_in   = chunks_ff;
      seq_in      = seq_ff;
      tag_in      = tag_ff;
      got_in      = got_ff;
      wptr_in     = wptr_ff;
      left_in     = left_ff;
      clr_left_in = clr_left_ff;
      status_in   = ST_IGNORED;
      rd_hit_in   = 1'b0;
      rd_req      = 1'b0;
      mem_we      = 1'b0;
      mem_waddr   = clr_addr[AW-1:0];
      mem_wdata   = '0;

      if (clearing) begin
         // zero one byte of the announced span, top down
         mem_we      = 1'b1;
         clr_left_in = clr_left_ff - 1'b1;
      end else if (pop) begin
         case (head_cmd.kind)
            CMD_BEGIN: begin
               if (recv_ff) begin
                  status_in = ST_BUSY;
               end else if (head_cmd.too_big) begin
                  status_in = ST_TOO_LARGE;
               end else begin
                  recv_in     = 1'b1;
                  fin_in      = 1'b0;
                  open_in     = 1'b0;
                  total_in    = head_cmd.total;
                  chunks_in   = head_cmd.chunks;
                  seq_in      = head_cmd.seq;
                  tag_in      = head_cmd.tag;
                  got_in      = '0;
                  left_in     = '0;
                  clr_left_in = head_cmd.total;
                  status_in   = ST_ACCEPTED;
               end
            end
            CMD_CHUNK: begin
               // abandon any open chunk first
               open_in = 1'b0;
               left_in = '0;
               if (!recv_ff || head_cmd.tag != tag_ff || head_cmd.cnum >= chunks_ff ||
                   head_cmd.too_far || head_cmd.end_pos > total_ff ||
                   head_cmd.short_pay) begin
                  status_in = ST_REJECTED;
               end else begin
                  wptr_in = head_cmd.offset;
                  if (head_cmd.size == '0) begin
                     status_in = ST_ACCEPTED;
                     if (got_ff >= total_ff) begin
                        fin_in    = 1'b1;
                        recv_in   = 1'b0;
                        status_in = ST_COMPLETE;
                     end
                  end else begin
                     left_in   = head_cmd.size;
                     open_in   = 1'b1;
                     status_in = ST_ACCEPTED;
                  end
               end
            end
            CMD_DATA: begin
               if (open_ff) begin
                  mem_we    = (wptr_ff < BUF_LIM);
                  mem_waddr = wptr_ff[AW-1:0];
                  mem_wdata = head_cmd.data;
                  wptr_in   = wptr_ff + 1'b1;
                  got_in    = got_inc;
                  left_in   = left_ff - 1'b1;
                  status_in = ST_ACCEPTED;
                  if (left_ff == LEN_W'(1)) begin
                     open_in = 1'b0;
                     if (got_inc >= total_ff) begin
                        fin_in    = 1'b1;
                        recv_in   = 1'b0;
                        status_in = ST_COMPLETE;
                     end
                  end
               end
            end
            CMD_READ: begin
               rd_req    = 1'b1;
               rd_hit_in = fin_ff && (POS_W'(head_cmd.raddr) < total_ff);
               status_in = ST_ACCEPTED;
            end
            CMD_CLEAR: begin
               recv_in   = 1'b0;
               fin_in    = 1'b0;
               open_in   = 1'b0;
               left_in   = '0;
               total_in  = '0;
               got_in    = '0;
               seq_in    = '0;
               status_in = ST_ACCEPTED;
            end
            default: begin
               status_in = ST_IGNORED;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         recv_ff       <= 1'b0;
         fin_ff        <= 1'b0;
         open_ff       <= 1'b0;
         total_ff      <= '0;
         chunks_ff     <= '0;
         seq_ff        <= '0;
         tag_ff        <= '0;
         got_ff        <= '0;
         wptr_ff       <= '0;
         left_ff       <= '0;
         clr_left_ff   <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         recv_ff       <= recv_in;
         fin_ff        <= fin_in;
         open_ff       <= open_in;
         total_ff      <= total_in;
         chunks_ff     <= chunks_in;
         seq_ff        <= seq_in;
         tag_ff        <= tag_in;
         got_ff        <= got_in;
         wptr_ff       <= wptr_in;
         left_ff       <= left_in;
         clr_left_ff   <= clr_left_in;
         rsp_strobe_ff <= pop;
      end
   end

   // result payload, flags taken after the command is applied
   always_ff @(posedge clock) begin
      if (pop) begin
         status_ff      <= status_in;
         rd_hit_ff      <= rd_hit_in;
         active_ff      <= recv_in;
         ready_fin_ff   <= fin_in;
         ready_total_ff <= total_in;
         done_seq_ff    <= seq_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_req) begin
         mem_q_ff <= mem[rd_addr];
      end
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_status        = status_ff;
   assign rsp_active_flag   = active_ff;
   assign rsp_complete_flag = ready_fin_ff;
   assign rsp_ready_size    = ready_fin_ff ? ready_total_ff[15:0] : 16'd0;
   assign rsp_done_seq      = done_seq_ff;
   assign rsp_read_data     = rd_hit_ff ? mem_q_ff : 8'd0;

   a_no_exec_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !pop)
      else $error("command executed during store clearing pass");

   a_recv_fin_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(recv_ff && fin_ff))
      else $error("transfer both receiving and finished");

   a_open_needs_recv: assert property (@(posedge clock) disable iff (reset)
      open_ff |-> (recv_ff && left_ff != '0))
      else $error("open chunk without active transfer or bytes left");

   a_result_follows_pop: assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_strobe)
      else $error("executed command produced no result");

endmodule

### hw/rtl/checkpoint_chunk_reassembler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// checkpoint_chunk_reassembler: chunked checkpoint receiver
// Rebuilds a chunked transfer in a byte store and reads it back.
// ----------------------------------------------------------------------------
// Items are taken one per cycle while busy is low and pass through a
// four-entry command queue to the executing back end, which retires one
// command per cycle outside a clearing pass. Each item is registered in the
// queue, waits there during any clearing pass and is executed from its head;
// its result appears on the rsp_ ports for one cycle, marked by rsp_strobe;
// it must be taken then, as there is no way to hold it. An accepted begin
// header zeroes the first total_len bytes (up to BUF_BYTES) of the byte
// store, one byte per cycle, and the back end executes nothing until the
// pass ends; items keep entering until the queue is full, and busy then
// stays high until the pass ends. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module checkpoint_chunk_reassembler
   import ckr_pkg::*;
#(
   parameter int BUF_BYTES  = 32768,
   parameter int CHUNK_SIZE = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_mode,
   input  logic [15:0] req_dest_node,
   input  logic [63:0] req_transfer_tag,
   input  logic [63:0] req_seq_number,
   input  logic [31:0] req_total_len,
   input  logic [31:0] req_chunk_count,
   input  logic [31:0] req_chunk_number,
   input  logic [31:0] req_chunk_len,
   input  logic [15:0] req_payload_len,
   input  logic [7:0]  req_data_byte,
   input  logic [14:0] req_read_addr,
   output logic        rsp_strobe,
   output logic [2:0]  rsp_status,
   output logic        rsp_active_flag,
   output logic        rsp_complete_flag,
   output logic [15:0] rsp_ready_size,
   output logic [63:0] rsp_done_seq,
   output logic [7:0]  rsp_read_data
);

   logic    accept;
   logic    push;
   cmd_type push_cmd;
   logic    full;
   logic    head_valid;
   cmd_type head_cmd;
   logic    pop;

   assign busy   = full;
   assign accept = start && !full;

   ckr_front #(
      .BUF_BYTES  (BUF_BYTES),
      .CHUNK_SIZE (CHUNK_SIZE)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .accept           (accept),
      .req_mode         (req_mode),
      .req_dest_node    (req_dest_node),
      .req_transfer_tag (req_transfer_tag),
      .req_seq_number   (req_seq_number),
      .req_total_len    (req_total_len),
      .req_chunk_count  (req_chunk_count),
      .req_chunk_number (req_chunk_number),
      .req_chunk_len    (req_chunk_len),
      .req_payload_len  (req_payload_len),
      .req_data_byte    (req_data_byte),
      .req_read_addr    (req_read_addr),
      .push             (push),
      .push_cmd         (push_cmd)
   );

   ckr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .pop        (pop),
      .full       (full),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   ckr_back #(
      .BUF_BYTES (BUF_BYTES)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .head_valid        (head_valid),
      .head_cmd          (head_cmd),
      .pop               (pop),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_active_flag   (rsp_active_flag),
      .rsp_complete_flag (rsp_complete_flag),
      .rsp_ready_size    (rsp_ready_size),
      .rsp_done_seq      (rsp_done_seq),
      .rsp_read_data     (rsp_read_data)
   );

endmodule
